FILE: rtl/core/csmv_pkg.sv
// Shared types and constants of the scaled sparse matrix-vector core.
package csmv_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_NONZERO = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCALE     = 2'd0;
    localparam logic [1:0] CFG_FIRST_ROW = 2'd1;
    localparam logic [1:0] CFG_END_ROW   = 2'd2;

    localparam logic [63:0] SCALE_RESET     = 64'h3FF0_0000_0000_0000;
    localparam logic [9:0]  FIRST_ROW_RESET = 10'd0;
    localparam logic [10:0] END_ROW_RESET   = 11'd1024;

    // Floating-point unit operations.
    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

endpackage

FILE: rtl/core/csmv_ifs.sv
// Stream and configuration interfaces of the scaled sparse matrix-vector core.
interface csmv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  index;
    logic [63:0] value;
    logic        row_last;

    modport source (output valid, output kind, output index, output value,
                    output row_last, input ready);
    modport sink (input valid, input kind, input index, input value,
                  input row_last, output ready);
    modport mon (input valid, input kind, input index, input value,
                 input row_last, input ready);
endinterface

interface csmv_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_sum;
    logic [9:0]  row_number;
    logic        range_done;

    modport source (output valid, output row_sum, output row_number,
                    output range_done, input ready);
    modport sink (input valid, input row_sum, input row_number,
                  input range_done, output ready);
    modport mon (input valid, input row_sum, input row_number,
                 input range_done, input ready);
endinterface

interface csmv_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [63:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
    modport mon (input valid, input reg_index, input wr_data, input ready);
endinterface

FILE: rtl/core/csmv_ram.sv
// Generic single-port RAM with registered read data.
module csmv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/csmv_fpu.sv
// Shared multicycle double-precision multiply/add unit with round to nearest even.
module csmv_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csmv_pkg::t_fpu_req i_req,
    output csmv_pkg::t_fpu_rsp o_rsp
);
    import csmv_pkg::*;

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_MUL    = 3'd1;
    localparam logic [2:0] F_ALIGN  = 3'd2;
    localparam logic [2:0] F_NORM   = 3'd3;
    localparam logic [2:0] F_DENORM = 3'd4;
    localparam logic [2:0] F_ROUND  = 3'd5;
    localparam logic [2:0] F_DONE   = 3'd6;

    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    // Right shift that folds every bit shifted out into the lowest bit.
    function automatic logic [107:0] rsh_sticky(input logic [107:0] v,
                                                input logic [12:0] n);
        logic [107:0] s;
        logic [107:0] mask;
        logic         lost;
        if (n >= 13'd108) begin
            s    = '0;
            lost = |v;
        end else begin
            s    = v >> n;
            mask = ~({108{1'b1}} << n);
            lost = |(v & mask);
        end
        return {s[107:1], s[0] | lost};
    endfunction

    logic [2:0]         r_state;
    logic               r_sign;
    logic signed [12:0] r_e;
    logic [107:0]       r_m;
    logic [52:0]        r_ma;
    logic [52:0]        r_mb;
    logic [10:0]        r_sh;
    logic               r_sub;
    logic [2:0]         r_cnt;
    logic [53:0]        r_pp;
    logic [63:0]        r_res;

    logic        sa, sb;
    logic [10:0] ea_f, eb_f, ea, eb;
    logic [52:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic        special;
    logic [63:0] sres;

    always_comb begin
        sa     = i_req.a[63];
        sb     = i_req.b[63];
        ea_f   = i_req.a[62:52];
        eb_f   = i_req.b[62:52];
        a_nan  = (ea_f == 11'h7FF) && (i_req.a[51:0] != '0);
        b_nan  = (eb_f == 11'h7FF) && (i_req.b[51:0] != '0);
        a_inf  = (ea_f == 11'h7FF) && (i_req.a[51:0] == '0);
        b_inf  = (eb_f == 11'h7FF) && (i_req.b[51:0] == '0);
        a_zero = (i_req.a[62:0] == '0);
        b_zero = (i_req.b[62:0] == '0);
        ma     = {|ea_f, i_req.a[51:0]};
        mb     = {|eb_f, i_req.b[51:0]};
        ea     = (|ea_f) ? ea_f : 11'd1;
        eb     = (|eb_f) ? eb_f : 11'd1;
        a_big  = (i_req.a[62:0] >= i_req.b[62:0]);

        special = 1'b1;
        sres    = '0;
        if (a_nan) begin
            sres = i_req.a | QUIET_BIT;
        end else if (b_nan) begin
            sres = i_req.b | QUIET_BIT;
        end else if (i_req.op == FOP_MUL) begin
            if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                sres = DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
                sres = {sa ^ sb, 11'h7FF, 52'd0};
            end else if (a_zero || b_zero) begin
                sres = {sa ^ sb, 63'd0};
            end else begin
                special = 1'b0;
            end
        end else begin
            if (a_inf && b_inf && (sa != sb)) begin
                sres = DEFAULT_NAN;
            end else if (a_inf) begin
                sres = i_req.a;
            end else if (b_inf) begin
                sres = i_req.b;
            end else if (a_zero && b_zero) begin
                sres = {sa & sb, 63'd0};
            end else if (a_zero) begin
                sres = i_req.b;
            end else if (b_zero) begin
                sres = i_req.a;
            end else if ((i_req.a[62:0] == i_req.b[62:0]) && (sa != sb)) begin
                // Exact cancellation gives positive zero.
                sres = '0;
            end else begin
                special = 1'b0;
            end
        end
    end

    // Partial products of 27 by 27 bits, one per cycle.
    logic [26:0] mul_x, mul_y;
    logic [53:0] pp_next;
    logic [107:0] pp_shifted;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin mul_x = r_ma[26:0];          mul_y = r_mb[26:0];          end
            2'd1: begin mul_x = r_ma[26:0];          mul_y = {1'b0, r_mb[52:27]}; end
            2'd2: begin mul_x = {1'b0, r_ma[52:27]}; mul_y = r_mb[26:0];          end
            default: begin mul_x = {1'b0, r_ma[52:27]}; mul_y = {1'b0, r_mb[52:27]}; end
        endcase
        pp_next = {27'd0, mul_x} * {27'd0, mul_y};
        case (r_cnt)
            3'd1:    pp_shifted = {54'd0, r_pp} << 2;
            3'd2:    pp_shifted = {54'd0, r_pp} << 29;
            3'd3:    pp_shifted = {54'd0, r_pp} << 29;
            3'd4:    pp_shifted = {54'd0, r_pp} << 56;
            default: pp_shifted = '0;
        endcase
    end

    // One shifter serves both alignment and denormalization.
    logic [107:0] sh_in, sh_out;
    logic [12:0]  sh_amt;
    logic [12:0]  e_gap;

    always_comb begin
        e_gap = 13'(13'sd1 - r_e);
        if (r_state == F_ALIGN) begin
            sh_in  = {1'b0, r_mb, 54'd0};
            sh_amt = {2'b00, r_sh};
        end else begin
            sh_in  = r_m;
            sh_amt = e_gap;
        end
        sh_out = rsh_sticky(sh_in, sh_amt);
    end

    logic [11:0] em1;
    logic        round_up;
    logic [63:0] rsum;

    always_comb begin
        em1      = 12'(r_e - 13'sd1);
        round_up = r_m[54] & ((|r_m[53:0]) | r_m[55]);
        rsum     = {em1, 52'd0} + {11'd0, r_m[107:55]} + {63'd0, round_up};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        if (special) begin
                            r_res   <= sres;
                            r_state <= F_DONE;
                        end else if (i_req.op == FOP_MUL) begin
                            r_sign  <= sa ^ sb;
                            r_ma    <= ma;
                            r_mb    <= mb;
                            r_e     <= $signed({2'b00, ea}) + $signed({2'b00, eb})
                                       - 13'sd1022;
                            r_m     <= '0;
                            r_cnt   <= '0;
                            r_state <= F_MUL;
                        end else begin
                            r_sub <= sa ^ sb;
                            if (a_big) begin
                                r_sign <= sa;
                                r_e    <= $signed({2'b00, ea}) + 13'sd1;
                                r_m    <= {1'b0, ma, 54'd0};
                                r_mb   <= mb;
                                r_sh   <= ea - eb;
                            end else begin
                                r_sign <= sb;
                                r_e    <= $signed({2'b00, eb}) + 13'sd1;
                                r_m    <= {1'b0, mb, 54'd0};
                                r_mb   <= ma;
                                r_sh   <= eb - ea;
                            end
                            r_state <= F_ALIGN;
                        end
                    end
                end
                F_MUL: begin
                    r_pp  <= pp_next;
                    r_m   <= r_m + pp_shifted;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_state <= F_NORM;
                    end
                end
                F_ALIGN: begin
                    r_m     <= r_sub ? (r_m - sh_out) : (r_m + sh_out);
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    if ((r_m[107:100] == '0) && (r_e > 13'sd8)) begin
                        r_m <= r_m << 8;
                        r_e <= r_e - 13'sd8;
                    end else if (!r_m[107] && (r_e > 13'sd1)) begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 13'sd1;
                    end else begin
                        r_state <= F_DENORM;
                    end
                end
                F_DENORM: begin
                    if (r_e < 13'sd1) begin
                        r_m <= sh_out;
                        r_e <= 13'sd1;
                    end
                    r_state <= F_ROUND;
                end
                F_ROUND: begin
                    if ((r_e >= 13'sd2048) || (rsum[63:52] >= 12'd2047)) begin
                        r_res <= {r_sign, 11'h7FF, 52'd0};
                    end else begin
                        r_res <= {r_sign, rsum[62:0]};
                    end
                    r_state <= F_DONE;
                end
                F_DONE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = (r_state == F_DONE);
    assign o_rsp.result = r_res;
endmodule

FILE: rtl/core/csr_sparse_matvec_scaled_core.sv
// Scaled sparse matrix-vector core over compressed rows in double precision.
// A load item leaves the core ready for the next item. A nonzero item
// occupies the core from its acceptance through a vector-store read and
// one or two passes through the shared floating multiply/add unit (product,
// then running sum), plus a third pass for the scale and an emit step on the
// last nonzero of a row. A pass skips the arithmetic when an operand is zero,
// infinite or NaN; otherwise its length is set by the unit's multiply steps
// for a product and by its normalization, which shifts at most eight bits a
// cycle. An empty-row item passes through the emit state, and its positive
// zero is registered into the output once the output register is free.
// Results leave through a registered output that holds while the sink stalls;
// a result waiting to enter that register holds the core busy, and loads are
// taken again once it has moved in. The vector store is not cleared after
// reset: entries must be loaded before a nonzero reads them.
module csr_sparse_matvec_scaled_core #(
    parameter int VECTOR_DEPTH = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    csmv_in_if.sink    i_in,
    csmv_cfg_if.sink   i_cfg,
    csmv_out_if.source o_out
);
    import csmv_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] STEP_PROD  = 2'd0;
    localparam logic [1:0] STEP_SUM   = 2'd1;
    localparam logic [1:0] STEP_SCALE = 2'd2;

    logic [2:0]  r_state;
    logic [1:0]  r_step;
    logic [63:0] r_scale;
    logic [9:0]  r_first_row;
    logic [10:0] r_end_row;
    logic [9:0]  r_row_cnt;
    logic        r_row_open;
    logic [63:0] r_acc;
    logic [63:0] r_val;
    logic        r_last;
    logic        r_hit;
    logic [63:0] r_opa;
    logic [63:0] r_opb;
    logic        r_fop;
    logic [63:0] r_sum;
    logic        r_out_valid;
    logic [63:0] r_out_sum;
    logic [9:0]  r_out_row;
    logic        r_out_done;

    logic        in_acc;
    logic        hit;
    logic [63:0] rdata;
    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;
    logic [9:0]  row_num;
    logic        row_done;
    logic [63:0] acc_new;
    logic        emit_go;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign hit         = (32'(i_in.index) < 32'(VECTOR_DEPTH));
    assign emit_go     = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    csmv_ram #(
        .WIDTH (64),
        .DEPTH (VECTOR_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.kind == KIND_LOAD) && hit),
        .i_addr  (AW'(i_in.index)),
        .i_wdata (i_in.value),
        .o_rdata (rdata)
    );

    assign fpu_req.start = (r_state == ST_ISSUE);
    assign fpu_req.op    = r_fop;
    assign fpu_req.a     = r_opa;
    assign fpu_req.b     = r_opb;

    csmv_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    assign row_num  = r_first_row + r_row_cnt;
    assign row_done = (({1'b0, row_num} + 11'd1) == r_end_row);

    always_comb begin
        acc_new = r_acc;
        if ((r_step == STEP_PROD) || (r_step == STEP_SUM)) begin
            acc_new = fpu_rsp.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RESET;
            r_first_row <= FIRST_ROW_RESET;
            r_end_row   <= END_ROW_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_SCALE:     r_scale     <= i_cfg.wr_data;
                CFG_FIRST_ROW: r_first_row <= i_cfg.wr_data[9:0];
                CFG_END_ROW:   r_end_row   <= i_cfg.wr_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_cnt   <= '0;
            r_row_open  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !emit_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.kind == KIND_NONZERO) begin
                            r_val   <= i_in.value;
                            r_last  <= i_in.row_last;
                            r_hit   <= hit;
                            r_state <= ST_READ;
                        end else if (i_in.kind == KIND_EMPTY) begin
                            r_sum   <= '0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_READ: begin
                    r_opa   <= r_val;
                    r_opb   <= r_hit ? rdata : 64'd0;
                    r_fop   <= FOP_MUL;
                    r_step  <= STEP_PROD;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (fpu_rsp.done) begin
                        if (r_step == STEP_SCALE) begin
                            r_sum   <= fpu_rsp.result;
                            r_state <= ST_EMIT;
                        end else if ((r_step == STEP_PROD) && r_row_open) begin
                            r_opa   <= r_acc;
                            r_opb   <= fpu_rsp.result;
                            r_fop   <= FOP_ADD;
                            r_step  <= STEP_SUM;
                            r_state <= ST_ISSUE;
                        end else begin
                            // The first product of a row is taken as the sum as is.
                            r_acc      <= acc_new;
                            r_row_open <= 1'b1;
                            if (r_last) begin
                                r_opa   <= acc_new;
                                r_opb   <= r_scale;
                                r_fop   <= FOP_MUL;
                                r_step  <= STEP_SCALE;
                                r_state <= ST_ISSUE;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= r_sum;
                        r_out_row   <= row_num;
                        r_out_done  <= row_done;
                        r_row_cnt   <= row_done ? 10'd0 : (r_row_cnt + 10'd1);
                        r_row_open  <= 1'b0;
                        r_acc       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.row_sum    = r_out_sum;
    assign o_out.row_number = r_out_row;
    assign o_out.range_done = r_out_done;
endmodule

FILE: rtl/core/csmv_checker.sv
// Port-level assertions for the scaled sparse matrix-vector core.
module csmv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_kind,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_row_sum,
    input logic [9:0]  i_out_row_number,
    input logic        i_out_range_done
);
    import csmv_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row_sum)
            && $stable(i_out_row_number) && $stable(i_out_range_done))
        else $error("stalled result changed");

    // Nonzero and empty-row requests keep the core busy for the next cycle.
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready
            && ((i_in_kind == KIND_NONZERO) || (i_in_kind == KIND_EMPTY))
        |=> !i_in_ready)
        else $error("core ready right after a nonzero or empty-row request");

    // After a load the core is ready again in the next cycle.
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_LOAD) |=> i_in_ready)
        else $error("core not ready after a load request");
endmodule

bind csr_sparse_matvec_scaled_core csmv_checker u_csmv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_kind        (i_in.kind),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_row_sum    (o_out.row_sum),
    .i_out_row_number (o_out.row_number),
    .i_out_range_done (o_out.range_done)
);
